[rtl/core/ibb_pkg.sv]
// ----------------------------------------------------------------------------
// IR beam-break detector package
// Shared widths, scan kinds, lane control and divider constants.
// ----------------------------------------------------------------------------
package ibb_pkg;

    localparam int NUM_SENSORS       = 6;
    localparam int SAMPLE_FIELD_BITS = 10;
    localparam int SUM_BITS          = 18;
    localparam int PROGRESS_BITS     = 8;

    localparam int CAL_COUNT_DEFAULT   = 200;
    localparam int SAMPLE_BITS_DEFAULT = 10;

    localparam int S_TDATA_BITS = 64;
    localparam int M_TDATA_BITS = 16;

    localparam int LOAD_LATENCY = 3;

    localparam logic KIND_DETECT = 1'b0;
    localparam logic KIND_CAL    = 1'b1;

    // Exact floor division by five of a value below 2^(SUM_BITS + 2).
    localparam int          DIV5_IN_BITS   = SUM_BITS + 2;
    localparam int          DIV5_MULT_BITS = DIV5_IN_BITS + 1;
    localparam int          DIV5_SHIFT     = DIV5_IN_BITS + 3;
    localparam logic [63:0] DIV5_MULT_FULL = ((64'd1 << DIV5_SHIFT) + 64'd4) / 64'd5;

    typedef struct packed {
        logic accum;
        logic finish;
        logic load;
    } lane_ctrl_t;

endpackage

[rtl/core/ir_beam_break_detector.sv]
// ----------------------------------------------------------------------------
// IR beam-break detector
// Six-sensor calibration and beam-break mask generation.
// ----------------------------------------------------------------------------
// The block accepts one scan per clock cycle while the output is not held by
// m_tready, and returns one result per scan through a registered output stage,
// so a full stream runs at one scan per cycle. Apart from back-pressure, the only
// exception is the calibration scan that completes a run: after it is accepted,
// s_tready stays low while each lane's two-multiplier divide pipeline loads the
// new threshold, so the next scan waits until the load is done.
module ir_beam_break_detector #(
    parameter int CAL_COUNT   = ibb_pkg::CAL_COUNT_DEFAULT,
    parameter int SAMPLE_BITS = ibb_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sample_0 .. sample_5, 10 bits each from bit 0 up, zero padded.
    input  logic [ibb_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // kind.
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // blocked_mask [5:0], calibration_progress [13:6], zero padded.
    output logic [ibb_pkg::M_TDATA_BITS-1:0]  m_tdata,
    // calibration_done.
    output logic [0:0]                        m_tuser
);

    localparam int NS  = ibb_pkg::NUM_SENSORS;
    localparam int SFB = ibb_pkg::SAMPLE_FIELD_BITS;
    localparam int PB  = ibb_pkg::PROGRESS_BITS;
    localparam int LL  = ibb_pkg::LOAD_LATENCY;

    logic                  accept;
    logic                  is_cal;
    logic                  done_now;
    logic [PB-1:0]         cnt_inc;
    logic [PB-1:0]         scan_count_reg;
    logic [PB-1:0]         scan_count_next;
    logic [LL-1:0]         busy_reg;
    logic [LL-1:0]         busy_next;
    logic [NS-1:0]         lane_blocked;
    ibb_pkg::lane_ctrl_t   lane_ctrl;

    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [NS-1:0]         mask_reg;
    logic [PB-1:0]         progress_reg;
    logic                  done_reg;

    assign s_tready = (busy_reg == '0) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign is_cal   = (s_tuser[0] == ibb_pkg::KIND_CAL);
    assign cnt_inc  = scan_count_reg + PB'(1);
    assign done_now = is_cal && (cnt_inc >= PB'(CAL_COUNT));

    assign lane_ctrl.accum  = accept && is_cal;
    assign lane_ctrl.finish = accept && done_now;
    assign lane_ctrl.load   = busy_reg[LL-1];

    assign busy_next = {busy_reg[LL-2:0], lane_ctrl.finish};

    always_comb begin
        scan_count_next = scan_count_reg;
        if (lane_ctrl.finish) begin
            scan_count_next = '0;
        end else if (lane_ctrl.accum) begin
            scan_count_next = cnt_inc;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_lane
        ibb_lane #(
            .CAL_COUNT   (CAL_COUNT),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .sample  (s_tdata[i*SFB +: SFB]),
            .blocked (lane_blocked[i])
        );
    end

    assign m_tvalid_next = accept || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_count_reg <= '0;
            busy_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            scan_count_reg <= scan_count_next;
            busy_reg       <= busy_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mask_reg     <= is_cal ? '0 : lane_blocked;
            done_reg     <= done_now;
            progress_reg <= scan_count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(ibb_pkg::M_TDATA_BITS - NS - PB)'(0), progress_reg, mask_reg};
    assign m_tuser  = done_reg;

    a_busy_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg != '0) |-> !s_tready)
        else $error("Scan accepted while thresholds were loading.");

    a_finish_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_ctrl.finish |=> !s_tready)
        else $error("Input not held off after a completed calibration run.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_count_reg < PB'(CAL_COUNT))
        else $error("Calibration scan count reached the run length.");

    a_done_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("Completed calibration result carries a mask or progress.");

endmodule

[rtl/core/ibb_lane.sv]
// ----------------------------------------------------------------------------
// IR beam-break detector sensor lane
// Accumulates calibration samples, derives the threshold and compares.
// ----------------------------------------------------------------------------
module ibb_lane #(
    parameter int CAL_COUNT   = ibb_pkg::CAL_COUNT_DEFAULT,
    parameter int SAMPLE_BITS = ibb_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ibb_pkg::lane_ctrl_t                  ctrl,
    input  logic [ibb_pkg::SAMPLE_FIELD_BITS-1:0] sample,
    output logic                                 blocked
);

    localparam int SMP_W = (SAMPLE_BITS < ibb_pkg::SAMPLE_FIELD_BITS) ?
                           SAMPLE_BITS : ibb_pkg::SAMPLE_FIELD_BITS;
    localparam int SUM_W    = ibb_pkg::SUM_BITS;
    localparam int DIV_LOG  = $clog2(CAL_COUNT);
    localparam int DIV_SH   = SUM_W + DIV_LOG;
    localparam int MULT_W   = SUM_W + 1;
    localparam logic [63:0] MULT_FULL =
        ((64'd1 << DIV_SH) + 64'(CAL_COUNT) - 64'd1) / 64'(CAL_COUNT);
    localparam int PROD1_W  = SUM_W + MULT_W;
    localparam int D5_IN_W  = ibb_pkg::DIV5_IN_BITS;
    localparam int D5_M_W   = ibb_pkg::DIV5_MULT_BITS;
    localparam int PROD2_W  = D5_IN_W + D5_M_W;

    localparam logic [MULT_W-1:0] DIV_MULT = MULT_FULL[MULT_W-1:0];
    localparam logic [D5_M_W-1:0] DIV5_MULT = ibb_pkg::DIV5_MULT_FULL[D5_M_W-1:0];

    logic [SMP_W-1:0]       smp;
    logic [SUM_W:0]         sum_add;
    logic [SUM_W-1:0]       sum_sat;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [SUM_W-1:0]       div_in_reg;
    logic [PROD1_W-1:0]     prod1_reg;
    logic [SUM_W-1:0]       avg;
    logic [D5_IN_W-1:0]     avg4;
    logic [PROD2_W-1:0]     prod2_reg;
    logic [D5_IN_W-1:0]     thr_full;
    logic [SAMPLE_BITS-1:0] thr_reg;
    logic [SAMPLE_BITS-1:0] thr_next;

    assign smp     = sample[SMP_W-1:0];
    assign sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(smp);
    assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

    always_comb begin
        sum_next = sum_reg;
        if (ctrl.finish) begin
            sum_next = '0;
        end else if (ctrl.accum) begin
            sum_next = sum_sat;
        end
    end

    assign avg      = SUM_W'(prod1_reg >> DIV_SH);
    assign avg4     = {avg, 2'b00};
    assign thr_full = D5_IN_W'(prod2_reg >> ibb_pkg::DIV5_SHIFT);
    assign thr_next = ctrl.load ? thr_full[SAMPLE_BITS-1:0] : thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            thr_reg <= '0;
        end else begin
            sum_reg <= sum_next;
            thr_reg <= thr_next;
        end
    end

    // Threshold pipeline: floor(sum / CAL_COUNT), then floor(avg * 4 / 5).
    always_ff @(posedge aclk) begin
        if (ctrl.finish) begin
            div_in_reg <= sum_sat;
        end
        prod1_reg <= PROD1_W'(div_in_reg) * PROD1_W'(DIV_MULT);
        prod2_reg <= PROD2_W'(avg4) * PROD2_W'(DIV5_MULT);
    end

    assign blocked = (SAMPLE_BITS'(smp) <= thr_reg);

endmodule
